// File: rtl/hkvs_pkg.sv
// ----------------------------------------------------------------------------
// hkvs_pkg
// shared types, sizes and codes of the hashed key-value store
// ----------------------------------------------------------------------------
package hkvs_pkg;

   localparam int BUCKETS   = 64;
   localparam int WAYS      = 4;
   localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam bit BKT_POW2  = ((1 << BKT_W) == BUCKETS);

   // rounded-up reciprocal of the bucket count, scaled by 2^(32 + BKT_W)
   localparam logic [32:0] BKT_RECIP =
      33'(((64'd1 << (32 + BKT_W)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

   localparam logic [31:0] FNV_BASIS      = 32'h811c_9dc5;
   localparam logic [31:0] FNV_MULTIPLIER = 32'h0100_0193;

   localparam logic [1:0] ACT_SET    = 2'd0;
   localparam logic [1:0] ACT_GET    = 2'd1;
   localparam logic [1:0] ACT_EXISTS = 2'd2;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_UPDATED  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_LOOKUP   = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        found;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] value;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

endpackage

// File: rtl/hashed_key_value_store_unit.sv
// ----------------------------------------------------------------------------
// hashed_key_value_store_unit
// fnv-1a hashed key-value store: set, get and exists over bucketed ways
// ----------------------------------------------------------------------------
// path: the request transfer starts the hash multiplies, then the bucket
//   memory read, then the compare and write back that registers the response
// occupancy: one request in flight; a new one is taken only back in idle, after
//   the shared hash multiplier and the single read-modify-write of the bucket row
// a bucket count that is not a power of two adds the reciprocal quotient and remainder steps
// reset: valid bits clear at once, no clearing pass; rows read only under a valid bit
module hashed_key_value_store_unit
   import hkvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_HASH = 3'b010,
      S_CMP  = 3'b100
   } ctl_state_type;

   ctl_state_type    state_ff, state_in;
   req_type          item_ff, item_in;
   logic [BKT_W-1:0] bkt_ff, bkt_in;
   logic [WAYS-1:0]  vrow_ff, vrow_in;
   logic [WAYS-1:0]  valid_ff [BUCKETS];
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             req_xfer;
   logic             hash_done;
   logic [BKT_W-1:0] hash_bucket;
   logic             rd_en;
   row_type          rd_row;
   logic             wr_en;
   row_type          wr_row;
   logic             can_load;
   logic             set_valid;

   logic             hit_any, free_any;
   logic [WAY_W-1:0] hit_way, free_way;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rd_en     = (state_ff == S_HASH) && hash_done;
   assign can_load  = (state_ff == S_CMP) && (!rsp_valid_ff || rsp_ready);

   hkvs_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (req_xfer),
      .key    (req_data.key),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   hkvs_bucket_ram u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (hash_bucket),
      .rd_row  (rd_row),
      .wr_en   (wr_en),
      .wr_addr (bkt_ff),
      .wr_row  (wr_row)
   );

   // first matching way and lowest free way
   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (vrow_ff[w]) begin
            if (!hit_any && (rd_row[w].key == item_ff.key)) begin
               hit_any = 1'b1;
               hit_way = WAY_W'(w);
            end
         end else if (!free_any) begin
            free_any = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      wr_row    = rd_row;
      wr_en     = 1'b0;
      set_valid = 1'b0;
      rsp_in    = rsp_ff;
      if (can_load) begin
         rsp_in.read_value = '0;
         rsp_in.found      = hit_any;
         rsp_in.status     = ST_LOOKUP;
         unique case (item_ff.action)
            ACT_SET: begin
               if (hit_any) begin
                  wr_row[hit_way].value = item_ff.value;
                  wr_en                 = 1'b1;
                  rsp_in.status         = ST_UPDATED;
               end else if (free_any) begin
                  wr_row[free_way].key   = item_ff.key;
                  wr_row[free_way].value = item_ff.value;
                  wr_en                  = 1'b1;
                  set_valid              = 1'b1;
                  rsp_in.status          = ST_INSERTED;
               end else begin
                  rsp_in.status = ST_FULL;
               end
            end
            ACT_GET: begin
               if (hit_any) begin
                  rsp_in.read_value = rd_row[hit_way].value;
               end
            end
            default: begin
               // exists query, unused code as well
               rsp_in.read_value = '0;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      bkt_in       = bkt_ff;
      vrow_in      = vrow_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               item_in  = req_data;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               bkt_in   = hash_bucket;
               vrow_in  = valid_ff[hash_bucket];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BUCKETS; b++) begin
            valid_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (set_valid) begin
            valid_ff[bkt_ff][free_way] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      bkt_ff  <= bkt_in;
      vrow_ff <= vrow_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH))
      else $error("hash finished outside the hash wait");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_write_only_set: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == S_CMP) && (item_ff.action == ACT_SET)))
      else $error("bucket row written outside a set");

   a_status_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_data.status == ST_INSERTED) || (rsp_data.status == ST_FULL)))
      |-> !rsp_data.found)
      else $error("insert or full reported with key present");

endmodule

// File: rtl/hkvs_hash.sv
// ----------------------------------------------------------------------------
// hkvs_hash
// fnv-1a over the four key bytes, one multiply per cycle, then bucket select
// ----------------------------------------------------------------------------
module hkvs_hash
   import hkvs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      key,
   output logic             done,
   output logic [BKT_W-1:0] bucket
);

   typedef enum logic [4:0] {
      H_IDLE = 5'b00001,
      H_MUL  = 5'b00010,
      H_QUO  = 5'b00100,
      H_REM  = 5'b01000,
      H_DONE = 5'b10000
   } hash_state_type;

   hash_state_type   state_ff, state_in;
   logic [1:0]       byte_cnt_ff, byte_cnt_in;
   logic [31:0]      key_ff, key_in;
   logic [31:0]      h_ff, h_in;
   logic [31:0]      quot_ff, quot_in;
   logic [BKT_W-1:0] bucket_ff, bucket_in;

   logic [63:0]      prod_full;
   logic [31:0]      prod;
   logic [7:0]       next_byte;
   logic [64:0]      recip_full;
   logic [31:0]      quot_next;
   logic [31:0]      rem_full;

   assign prod_full = h_ff * FNV_MULTIPLIER;
   assign prod      = prod_full[31:0];
   assign next_byte = key_ff[{byte_cnt_ff + 2'd1, 3'b000} +: 8];

   // remainder by reciprocal multiply: quotient registered in H_QUO, remainder from it in H_REM
   assign recip_full = 65'(h_ff) * BKT_RECIP;
   assign quot_next  = 32'(recip_full >> (32 + BKT_W));
   assign rem_full   = h_ff - quot_ff * 32'(BUCKETS);

   always_comb begin
      state_in    = state_ff;
      byte_cnt_in = byte_cnt_ff;
      key_in      = key_ff;
      h_in        = h_ff;
      quot_in     = quot_ff;
      bucket_in   = bucket_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               key_in      = key;
               h_in        = FNV_BASIS ^ {24'd0, key[7:0]};
               byte_cnt_in = 2'd0;
               state_in    = H_MUL;
            end
         end
         H_MUL: begin
            byte_cnt_in = byte_cnt_ff + 2'd1;
            if (byte_cnt_ff == 2'd3) begin
               h_in = prod;
               if (BKT_POW2) begin
                  bucket_in = prod[BKT_W-1:0];
                  state_in  = H_DONE;
               end else begin
                  state_in = H_QUO;
               end
            end else begin
               h_in = prod ^ {24'd0, next_byte};
            end
         end
         H_QUO: begin
            quot_in  = quot_next;
            state_in = H_REM;
         end
         H_REM: begin
            bucket_in = rem_full[BKT_W-1:0];
            state_in  = H_DONE;
         end
         H_DONE: begin
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_cnt_ff <= byte_cnt_in;
      key_ff      <= key_in;
      h_ff        <= h_in;
      quot_ff     <= quot_in;
      bucket_ff   <= bucket_in;
   end

   assign done   = (state_ff == H_DONE);
   assign bucket = bucket_ff;

endmodule

// File: rtl/hkvs_bucket_ram.sv
// ----------------------------------------------------------------------------
// hkvs_bucket_ram
// one row per bucket holding the key and value of every way, registered read
// ----------------------------------------------------------------------------
module hkvs_bucket_ram
   import hkvs_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [BKT_W-1:0] rd_addr,
   output row_type          rd_row,
   input  logic             wr_en,
   input  logic [BKT_W-1:0] wr_addr,
   input  row_type          wr_row
);

   row_type mem [BUCKETS];
   row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule
